>>> src/dnswnd_pkg.sv
`timescale 1ns / 1ps

package dnswnd_pkg;

  localparam int NAME_MAX_BYTES_DEF = 255;

  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNCATED = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_end;
  } sym_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       name_done;
    logic [1:0] status;
    logic [7:0] label_count;
    logic [7:0] encoded_length;
  } txt_t;

endpackage

>>> src/dns_wire_name_decoder.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// sym      in         sym_valid/sym_stall   sym_data : in_byte, buffer_end
// txt      out        txt_valid/txt_stall   txt_data : text_char, name_done, status,
//                                                      label_count, encoded_length
//
// One wire byte is taken each cycle while sym_stall is low; its result, if any, is computed
// by a single decode step from the name counters and the byte, and registered in the output buffer.
// A two-entry output buffer (result register plus skid) lets a byte be taken while a
// result is stalled; sym_stall rises only once both entries are full.
// Synchronous reset puts the decoder at the start of a new name with both entries empty.

module dns_wire_name_decoder #(
  parameter int NAME_MAX_BYTES = dnswnd_pkg::NAME_MAX_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sym_valid,
  output logic             sym_stall,
  input  dnswnd_pkg::sym_t sym_data,
  output logic             txt_valid,
  input  logic             txt_stall,
  output dnswnd_pkg::txt_t txt_data
);
  import dnswnd_pkg::*;

  // Room for a full-length name plus one maximal label beyond it.
  localparam int POS_W = $clog2(NAME_MAX_BYTES + 257);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(NAME_MAX_BYTES);
  localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_SAT   = POS_W'(255);

  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,
    PH_LABEL = 2'd1,
    PH_SKIP  = 2'd2
  } phase_t;

  function automatic logic [7:0] sat8(input logic [POS_W-1:0] v);
    return (v > POS_SAT) ? 8'hFF : v[7:0];
  endfunction

  phase_t           phase, phase_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       label_remaining, label_remaining_next;
  logic [7:0]       cur_len, cur_len_next;
  logic [7:0]       labels_seen, labels_seen_next;

  logic             skid_valid;
  txt_t             skid_data;

  logic             accept;
  logic             has_res;
  txt_t             res;
  logic [7:0]       b;
  logic             last;
  logic [POS_W-1:0] pos_inc;
  logic [7:0]       labels_inc;

  assign sym_stall = skid_valid;
  assign accept    = sym_valid && !skid_valid;
  assign b         = sym_data.in_byte;
  assign last      = sym_data.buffer_end;
  assign pos_inc   = byte_position + POS_ONE;

  always_comb begin
    labels_inc = labels_seen;
    if (label_remaining == cur_len && !(cur_len == 8'd1 && b == CHAR_STAR) &&
        labels_seen != 8'hFF) begin
      labels_inc = labels_seen + 8'd1;
    end
  end

  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    label_remaining_next = label_remaining;
    cur_len_next         = cur_len;
    labels_seen_next     = labels_seen;
    has_res              = 1'b0;
    res                  = '0;

    unique case (phase)
      PH_SKIP: begin
        if (last) begin
          phase_next         = PH_LEN;
          byte_position_next = '0;
          label_remaining_next = '0;
          cur_len_next       = '0;
          labels_seen_next   = '0;
        end
      end
      PH_LABEL: begin
        has_res              = 1'b1;
        labels_seen_next     = labels_inc;
        byte_position_next   = pos_inc;
        label_remaining_next = label_remaining - 8'd1;
        if (last) begin
          res.name_done      = 1'b1;
          res.status         = ST_TRUNCATED;
          res.label_count    = labels_inc;
          res.encoded_length = sat8(pos_inc);
          // The byte after the buffer end starts a new name.
          phase_next           = PH_LEN;
          byte_position_next   = '0;
          label_remaining_next = '0;
          cur_len_next         = '0;
          labels_seen_next     = '0;
        end else begin
          res.text_char = b;
          if (label_remaining == 8'd1) begin
            phase_next = PH_LEN;
          end
        end
      end
      default: begin
        // Expecting a length byte; the unused phase code behaves the same way.
        has_res = 1'b1;
        if (byte_position >= POS_LIMIT) begin
          res.name_done      = 1'b1;
          res.status         = (last && b != 8'd0) ? ST_TRUNCATED : ST_TOO_LONG;
          res.label_count    = labels_seen;
          res.encoded_length = sat8(byte_position);
        end else if (b == 8'd0) begin
          res.name_done      = 1'b1;
          res.status         = ST_OK;
          res.text_char      = (byte_position == '0) ? CHAR_SPACE : 8'd0;
          res.label_count    = labels_seen;
          res.encoded_length = sat8(pos_inc);
        end else if (last) begin
          res.name_done      = 1'b1;
          res.status         = ST_TRUNCATED;
          res.label_count    = labels_seen;
          res.encoded_length = sat8(pos_inc);
        end else begin
          cur_len_next         = b;
          label_remaining_next = b;
          phase_next           = PH_LABEL;
          byte_position_next   = pos_inc;
          // The first label gets no leading dot.
          has_res              = (byte_position != '0);
          res.text_char        = CHAR_DOT;
        end

        if (res.name_done) begin
          if (last) begin
            phase_next           = PH_LEN;
            byte_position_next   = '0;
            label_remaining_next = '0;
            cur_len_next         = '0;
            labels_seen_next     = '0;
          end else begin
            phase_next = PH_SKIP;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_LEN;
      byte_position   <= '0;
      label_remaining <= '0;
      cur_len         <= '0;
      labels_seen     <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      label_remaining <= label_remaining_next;
      cur_len         <= cur_len_next;
      labels_seen     <= labels_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      txt_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (txt_valid && !txt_stall) begin
      if (skid_valid) begin
        txt_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        txt_valid <= accept && has_res;
        txt_data  <= res;
      end
    end else if (accept && has_res) begin
      if (!txt_valid) begin
        txt_valid <= 1'b1;
        txt_data  <= res;
      end else begin
        skid_valid <= 1'b1;
        skid_data  <= res;
      end
    end
  end

`ifndef SYNTH
  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> txt_valid)
    else $error("skid entry held while result register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(txt_valid && txt_stall))
    else $error("skid entry filled without a stalled result");

  a_text_beat_clean: assert property (@(posedge clk) disable iff (rst)
    (txt_valid && !txt_data.name_done) |->
      (txt_data.status == ST_OK && txt_data.label_count == 8'd0 &&
       txt_data.encoded_length == 8'd0))
    else $error("text beat carries final-result fields");

  a_pos_bounded: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_LIMIT + POS_SAT)
    else $error("byte position beyond one label past the limit");

  a_restart_after_end: assert property (@(posedge clk) disable iff (rst)
    (accept && last && phase != PH_LABEL && (phase == PH_SKIP || res.name_done)) |=>
      (phase == PH_LEN && byte_position == '0 && labels_seen == 8'd0))
    else $error("name state not cleared after buffer end");
`endif

endmodule

>>> test/dns_name_checker.sv
`timescale 1ns / 1ps

module dns_name_checker #(
  parameter int NAME_MAX_BYTES = dnswnd_pkg::NAME_MAX_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sym_valid,
  input  logic             sym_stall,
  input  dnswnd_pkg::sym_t sym_data,
  input  logic             txt_valid,
  input  logic             txt_stall,
  input  dnswnd_pkg::txt_t txt_data,
  output int               fail_count,
  output int               pending,
  output int               beats_taken,
  output int               results_seen,
  output int               names_ok,
  output int               names_cut,
  output int               names_long
);

  import dnswnd_pkg::*;

  typedef enum logic [1:0] {
    WANT_LEN = 2'd0,
    IN_LABEL = 2'd1,
    SKIPPING = 2'd2
  } walk_t;

  walk_t      walk;
  logic [9:0] name_pos;
  logic [7:0] label_left;
  logic [7:0] label_len;
  logic [7:0] label_tally;

  txt_t       decoded_q[$];
  txt_t       fresh;
  bit         produced;
  txt_t       want;

  task automatic restart_name();
    walk        = WANT_LEN;
    name_pos    = '0;
    label_left  = '0;
    label_len   = '0;
    label_tally = '0;
  endtask

  task automatic close_name(input status_t st, input logic [7:0] ch, input logic [9:0] enc,
                            input logic stop);
    fresh.text_char      = ch;
    fresh.name_done      = 1'b1;
    fresh.status         = st;
    fresh.label_count    = label_tally;
    fresh.encoded_length = (enc > 10'd255) ? 8'hFF : enc[7:0];
    produced             = 1'b1;
    if (stop) begin
      restart_name();
    end else begin
      walk = SKIPPING;
    end
  endtask

  // Works out the text beat, if any, that one wire byte gives.
  task automatic decode_byte(input sym_t s);
    fresh    = '0;
    produced = 1'b0;
    case (walk)
      SKIPPING: begin
        if (s.buffer_end) begin
          restart_name();
        end
      end
      IN_LABEL: begin
        // The first byte of a label counts it, unless the label is a lone wildcard.
        if (label_left == label_len && !(label_len == 8'd1 && s.in_byte == CHAR_STAR) &&
            label_tally != 8'hFF) begin
          label_tally = label_tally + 8'd1;
        end
        name_pos   = name_pos + 10'd1;
        label_left = label_left - 8'd1;
        if (s.buffer_end) begin
          close_name(ST_TRUNCATED, 8'h00, name_pos, 1'b1);
        end else begin
          if (label_left == 8'd0) begin
            walk = WANT_LEN;
          end
          fresh.text_char = s.in_byte;
          produced        = 1'b1;
        end
      end
      default: begin
        if (name_pos >= NAME_MAX_BYTES) begin
          close_name((s.buffer_end && s.in_byte != 8'd0) ? ST_TRUNCATED : ST_TOO_LONG,
                     8'h00, name_pos, s.buffer_end);
        end else if (s.in_byte == 8'd0) begin
          close_name(ST_OK, (name_pos == 10'd0) ? CHAR_SPACE : 8'h00, name_pos + 10'd1,
                     s.buffer_end);
        end else if (s.buffer_end) begin
          close_name(ST_TRUNCATED, 8'h00, name_pos + 10'd1, 1'b1);
        end else begin
          label_len  = s.in_byte;
          label_left = s.in_byte;
          walk       = IN_LABEL;
          name_pos   = name_pos + 10'd1;
          if (name_pos > 10'd1) begin
            fresh.text_char = CHAR_DOT;
            produced        = 1'b1;
          end
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("[%0t] mismatch on %s: got 0x%0h, wanted 0x%0h", $time, what, got_v, want_v);
    fail_count++;
  endtask

  // A result beat taken at this edge always stems from an earlier byte, so it is
  // compared before the byte taken at the same edge is decoded.
  always @(posedge clk) begin
    if (rst) begin
      restart_name();
      decoded_q.delete();
    end else begin
      if (txt_valid && !txt_stall) begin
        results_seen++;
        if (decoded_q.size() == 0) begin
          report_mismatch("result beat with nothing outstanding", txt_data, 0);
        end else begin
          want = decoded_q.pop_front();
          if (txt_data.text_char !== want.text_char)
            report_mismatch("text_char", txt_data.text_char, want.text_char);
          if (txt_data.name_done !== want.name_done)
            report_mismatch("name_done", txt_data.name_done, want.name_done);
          if (txt_data.status !== want.status)
            report_mismatch("status", txt_data.status, want.status);
          if (txt_data.label_count !== want.label_count)
            report_mismatch("label_count", txt_data.label_count, want.label_count);
          if (txt_data.encoded_length !== want.encoded_length)
            report_mismatch("encoded_length", txt_data.encoded_length, want.encoded_length);
          if (want.name_done) begin
            case (status_t'(want.status))
              ST_OK:        names_ok++;
              ST_TRUNCATED: names_cut++;
              default:      names_long++;
            endcase
          end
        end
      end
      if (sym_valid && !sym_stall) begin
        beats_taken++;
        decode_byte(sym_data);
        if (produced) begin
          decoded_q.push_back(fresh);
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  import dnswnd_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst;
  logic sym_valid;
  logic sym_stall;
  sym_t sym_data;
  logic txt_valid;
  logic txt_stall;
  txt_t txt_data;

  int   fail_count;
  int   pending;
  int   beats_taken;
  int   results_seen;
  int   names_ok;
  int   names_cut;
  int   names_long;

  int   cycle_count = 0;
  bit   burst = 0;
  sym_t wire_q[$];
  int   items_sent = 0;
  int   long_done = 0;
  int   pick;

  dns_wire_name_decoder u_dut (
    .clk       (clk),
    .rst       (rst),
    .sym_valid (sym_valid),
    .sym_stall (sym_stall),
    .sym_data  (sym_data),
    .txt_valid (txt_valid),
    .txt_stall (txt_stall),
    .txt_data  (txt_data)
  );

  dns_name_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .sym_valid    (sym_valid),
    .sym_stall    (sym_stall),
    .sym_data     (sym_data),
    .txt_valid    (txt_valid),
    .txt_stall    (txt_stall),
    .txt_data     (txt_data),
    .fail_count   (fail_count),
    .pending      (pending),
    .beats_taken  (beats_taken),
    .results_seen (results_seen),
    .names_ok     (names_ok),
    .names_cut    (names_cut),
    .names_long   (names_long)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timed out after %0d cycles with %0d results outstanding", cycle_count, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  // The receiver stalls in segments: mostly open, some short stalls, a few long
  // ones, and now and then a long stretch with no stall at all.
  initial begin
    int r;
    int len;
    txt_stall = 1'b0;
    forever begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        txt_stall <= 1'b0;
        len = $urandom_range(1, 8);
      end else if (r < 85) begin
        txt_stall <= 1'b1;
        len = $urandom_range(1, 3);
      end else if (r < 93) begin
        txt_stall <= 1'b1;
        len = $urandom_range(10, 40);
      end else begin
        txt_stall <= 1'b0;
        len = $urandom_range(50, 200);
      end
      repeat (len) @(negedge clk);
    end
  end

  function automatic int pick_gap();
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Entered and left at a falling edge.
  task automatic send_beat(input sym_t s);
    int gap;
    bit taken;
    gap = pick_gap();
    repeat (gap) begin
      sym_valid <= 1'b0;
      @(negedge clk);
    end
    sym_valid <= 1'b1;
    sym_data  <= s;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !sym_stall;
      @(negedge clk);
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic e);
    sym_t s;
    s.in_byte    = b;
    s.buffer_end = e;
    wire_q.push_back(s);
  endtask

  task automatic flush_wire();
    burst = ($urandom_range(0, 99) < 15);
    items_sent += wire_q.size();
    foreach (wire_q[i]) send_beat(wire_q[i]);
    wire_q.delete();
  endtask

  function automatic logic [7:0] label_byte();
    if ($urandom_range(0, 11) == 0) return CHAR_STAR;
    return 8'($urandom_range(0, 255));
  endfunction

  // A complete name; the buffer ends on the root label or a few bytes later.
  task automatic build_good_name();
    int nlab;
    int r;
    int len;
    int tail;
    nlab = $urandom_range(0, 4);
    repeat (nlab) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        push_byte(8'd1, 1'b0);
        push_byte(CHAR_STAR, 1'b0);
      end else begin
        if (r < 25) len = 1;
        else if (r < 32) len = $urandom_range(11, 63);
        else len = $urandom_range(1, 10);
        push_byte(8'(len), 1'b0);
        repeat (len) push_byte(label_byte(), 1'b0);
      end
    end
    if ($urandom_range(0, 99) < 60) begin
      push_byte(8'd0, 1'b1);
    end else begin
      push_byte(8'd0, 1'b0);
      tail = $urandom_range(1, 4);
      for (int i = 1; i <= tail; i++) push_byte(8'($urandom_range(0, 255)), i == tail);
    end
  endtask

  // A name whose buffer ends at a random byte.
  task automatic build_cut_name();
    int k;
    build_good_name();
    k = $urandom_range(0, wire_q.size() - 1);
    while (wire_q.size() > k + 1) void'(wire_q.pop_back());
    wire_q[k].buffer_end = 1'b1;
  endtask

  task automatic build_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 1; i <= n; i++)
      push_byte(8'($urandom_range(0, 255)), (i == n) || ($urandom_range(0, 3) == 0));
  endtask

  // Labels until one short of the length limit or beyond, often landing exactly one short of it or on it.
  task automatic build_long_name();
    int p;
    int target;
    int room;
    int len;
    int r;
    p = 0;
    target = 254 + $urandom_range(0, 1);
    while (p < target) begin
      room = target - p;
      if (room >= 2 && $urandom_range(0, 1)) len = room - 1;
      else len = $urandom_range(1, 255);
      push_byte(8'(len), 1'b0);
      repeat (len) push_byte(label_byte(), 1'b0);
      p += 1 + len;
    end
    r = $urandom_range(0, 2);
    if (r == 0) begin
      push_byte(8'd0, 1'b1);
    end else if (r == 1) begin
      push_byte(8'($urandom_range(1, 255)), 1'b1);
    end else begin
      push_byte(8'd0, 1'b0);
      push_byte(8'($urandom_range(0, 255)), 1'b0);
      push_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    rst       = 1'b1;
    sym_valid = 1'b0;
    sym_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Bare root without buffer end, then skipped bytes up to the buffer end.
    push_byte(8'h00, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b1);
    // Bare root that is also the last byte of its buffer.
    push_byte(8'h00, 1'b1);
    // Wildcard label, then a label holding 0x61, 0xFF and 0x00.
    push_byte(8'h01, 1'b0);
    push_byte(CHAR_STAR, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h61, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    // Buffer ends inside a label.
    push_byte(8'h03, 1'b0);
    push_byte(8'h41, 1'b0);
    push_byte(8'h42, 1'b1);
    // Buffer ends on a length byte of 0xFF.
    push_byte(8'h01, 1'b0);
    push_byte(8'h7A, 1'b0);
    push_byte(8'hFF, 1'b1);
    // Buffer ends on a lone wildcard byte.
    push_byte(8'h01, 1'b0);
    push_byte(CHAR_STAR, 1'b1);
    // Label holding a dot, root without buffer end, one skipped byte.
    push_byte(8'h01, 1'b0);
    push_byte(CHAR_DOT, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b1);
    flush_wire();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (long_done < 2 && items_sent > 120 + 150 * long_done) begin
        build_long_name();
        long_done++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 65) build_good_name();
        else if (pick < 85) build_cut_name();
        else build_noise();
      end
      flush_wire();
    end
    sym_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("%0d wire bytes taken, %0d result beats checked", beats_taken, results_seen);
    $display("names closed: %0d ok, %0d cut short by buffer end, %0d over the length limit",
             names_ok, names_cut, names_long);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", fail_count, pending);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/dnswnd_pkg.sv
src/dns_wire_name_decoder.sv
test/dns_name_checker.sv
test/testbench.sv
